>>> rtl/mlfq_pkg.sv
// ============================================================================
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ============================================================================
package mlfq_pkg;

    localparam int SLOTS_DEF = 64;

    localparam logic [15:0] BOOST_RST = 16'd100;
    localparam logic [7:0]  QUANT0_RST = 8'd4;
    localparam logic [7:0]  QUANT1_RST = 8'd6;
    localparam logic [7:0]  QUANT2_RST = 8'd8;
    localparam logic [1:0]  PRIO_MAX = 2'd3;

    typedef enum logic [3:0] {
        OP_ADMIT  = 4'd0,
        OP_TICK   = 4'd1,
        OP_YIELD  = 4'd2,
        OP_SLEEP  = 4'd3,
        OP_WAKE   = 4'd4,
        OP_REMOVE = 4'd5,
        OP_SETPRI = 4'd6,
        OP_LOCK   = 4'd7,
        OP_UNLOCK = 4'd8,
        OP_SELECT = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ST_UNUSED   = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_SLEEPING = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_BAD   = 2'd2
    } t_status;

    localparam logic [1:0] CFG_BOOST  = 2'd0;
    localparam logic [1:0] CFG_QUANT0 = 2'd1;
    localparam logic [1:0] CFG_QUANT1 = 2'd2;
    localparam logic [1:0] CFG_QUANT2 = 2'd3;

    // Per-slot record carried around the ring
    typedef struct packed {
        logic [1:0]  st;
        logic [1:0]  lvl;
        logic [1:0]  prio;
        logic [31:0] arr;
        logic [7:0]  used;
        logic        lock;
    } t_slot;

    // One rotation command, broadcast to every cell
    typedef struct packed {
        logic        rot;
        logic        boost;
    } t_ring_ctl;

    // Search key: rank (lower wins) and arrival
    function automatic logic [2:0] rank_of(input t_slot s);
        logic [2:0] r;
        begin
            if (s.lvl == 2'd0) r = 3'd0;
            else if (s.lvl == 2'd1) r = 3'd1;
            else r = 3'd2 + {1'b0, s.prio};
            return r;
        end
    endfunction

endpackage

>>> rtl/mlfq_cell.sv
// ============================================================================
// mlfq_cell
// One slot record of the ring; shifts to its neighbor on each rotate step.
// ============================================================================
module mlfq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlfq_pkg::t_ring_ctl i_ctl,
    input  mlfq_pkg::t_slot     i_prev,
    output mlfq_pkg::t_slot     o_slot
);
    import mlfq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.rot) begin
            n_slot = i_prev;
            if (i_ctl.boost) begin
                n_slot.prio = PRIO_MAX;
                n_slot.lvl  = 2'd0;
                n_slot.used = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '{st: ST_UNUSED, lvl: 2'd0, prio: PRIO_MAX, arr: 32'd0,
                        used: 8'd0, lock: 1'b0};
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

>>> rtl/mlfq_task_scheduler_top.sv
// ============================================================================
// mlfq_task_scheduler_top
// Multilevel feedback queue scheduler over a ring of slot cells.
// ============================================================================
// Requests enter on the s_axis group: tdata = {new_priority, slot, op}.
// One result per request leaves on m_axis: tdata = {status, run_level,
// run_valid, run_slot}. Configuration registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight.
// The slot records sit in a ring of SLOTS cells. Every request rotates the
// ring once, so the head cell visits each slot: the addressed slot is
// updated there, select compares every runnable slot there, and a boost is
// applied to each slot as it passes the head. A select that finds a winner
// needs a second rotation to mark the winner running. One request is in
// flight at a time, so a new request is taken only once the last one is
// through. Reset empties all slots and loads the default register values.
// A stalled result stays in the output register; the next request is taken
// only once it has been delivered.
// ============================================================================
module mlfq_task_scheduler_top #(
    parameter int SLOTS = mlfq_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op[3:0], slot[9:4], new_priority[13:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // run_slot[5:0], run_valid[6], run_level[8:7],
                                        // status[10:9]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import mlfq_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PASS = 4'b0010,
        S_MARK = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [15:0] r_boost;
    logic [7:0]  r_q0, r_q1, r_q2;
    logic [31:0] r_tick, n_tick;
    logic [5:0]  r_run, n_run;
    logic        r_runv, n_runv;
    logic [1:0]  r_runl, n_runl;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_pos;       // slot number of the head cell
    t_op         r_op;
    logic [5:0]  r_slot;
    logic [3:0]  r_np;
    logic [1:0]  r_sts, n_sts;
    logic        r_boostp, n_boostp;
    logic        r_got, n_got;
    logic [2:0]  r_brank, n_brank;
    logic [31:0] r_barr, n_barr;
    logic [SW-1:0] r_bslot, n_bslot;
    logic [15:0] r_out;
    logic        r_ov;

    t_slot       w_cell [SLOTS];
    t_slot       w_head;
    t_slot       w_feed;
    t_ring_ctl   w_ctl;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_ring
            mlfq_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_prev (g == 0 ? w_feed : w_cell[g-1]),
                .o_slot (w_cell[g])
            );
        end
    endgenerate

    // Last cell holds slot r_pos; it feeds cell 0 after the update.
    assign w_head = w_cell[SLOTS-1];
    assign w_ctl.rot = (r_state == S_PASS) || (r_state == S_MARK);
    assign w_ctl.boost = 1'b0;

    logic w_hit, w_run_hit, w_in_rng;
    logic [2:0] w_rank;

    assign w_in_rng  = ({26'd0, r_slot} < 32'(SLOTS));
    assign w_hit     = w_in_rng && (r_pos == r_slot[SW-1:0]);
    assign w_run_hit = r_runv && (r_pos == r_run[SW-1:0]);
    assign w_rank    = rank_of(w_head);

    // Decode and apply global effects on acceptance
    logic w_acc;
    t_op  w_iop;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_iop = t_op'(s_axis_tdata[3:0]);

    always_comb begin
        w_feed  = w_head;
        n_tick  = r_tick;
        n_run   = r_run;
        n_runv  = r_runv;
        n_runl  = r_runl;
        n_sts   = r_sts;
        n_boostp = r_boostp;
        n_got   = r_got;
        n_brank = r_brank;
        n_barr  = r_barr;
        n_bslot = r_bslot;
        if (w_acc) begin
            n_got = 1'b0;
            n_boostp = (r_tick >= {16'd0, r_boost});
            n_sts = STS_OK;
            unique case (w_iop)
                OP_ADMIT, OP_WAKE, OP_REMOVE, OP_SETPRI: ;
                OP_TICK: if (r_tick != 32'hFFFF_FFFF) n_tick = r_tick + 32'd1;
                OP_YIELD, OP_SLEEP: begin
                    if (!r_runv) n_sts = STS_BAD;
                end
                OP_LOCK: begin
                    if (!r_runv) n_sts = STS_BAD;
                    else begin
                        n_tick = 32'd0;
                        n_runl = 2'd0;
                    end
                end
                OP_UNLOCK: begin
                    if (!r_runv) n_sts = STS_BAD;
                    else n_runl = 2'd0;
                end
                OP_SELECT: if (r_runv) n_sts = STS_BAD;
                default: n_sts = STS_BAD;
            endcase
        end
        if (r_state == S_PASS) begin
            unique case (r_op)
                OP_ADMIT: begin
                    if (w_hit && w_head.st == ST_UNUSED) begin
                        w_feed = '{st: ST_RUNNABLE, lvl: 2'd0, prio: PRIO_MAX,
                                   arr: r_tick, used: 8'd0, lock: 1'b0};
                    end
                end
                OP_TICK: begin
                    if (w_run_hit && w_head.used != 8'hFF)
                        w_feed.used = w_head.used + 8'd1;
                end
                OP_YIELD, OP_SLEEP: begin
                    if (w_run_hit) begin
                        if (w_head.lvl == 2'd0 && w_head.used >= r_q0) begin
                            w_feed.used = 8'd0;
                            w_feed.lvl = 2'd1;
                            w_feed.arr = r_tick;
                        end else if (w_head.lvl == 2'd1 && w_head.used >= r_q1) begin
                            w_feed.used = 8'd0;
                            w_feed.lvl = 2'd2;
                            w_feed.arr = r_tick;
                        end else if (w_head.lvl == 2'd2 && w_head.used >= r_q2) begin
                            w_feed.used = 8'd0;
                            if (w_head.prio != 2'd0) w_feed.prio = w_head.prio - 2'd1;
                        end
                        if (w_head.lock) begin
                            w_feed.lvl = 2'd0;
                            w_feed.arr = 32'd0;
                            w_feed.prio = PRIO_MAX;
                            w_feed.used = 8'd0;
                            if (r_boostp) w_feed.lock = 1'b0;
                        end
                        w_feed.st = (r_op == OP_YIELD) ? ST_RUNNABLE : ST_SLEEPING;
                    end
                    if (r_boostp && r_runv) begin
                        w_feed.prio = PRIO_MAX;
                        w_feed.lvl = 2'd0;
                        w_feed.used = 8'd0;
                    end
                end
                OP_WAKE: begin
                    if (w_hit && w_head.st == ST_SLEEPING) w_feed.st = ST_RUNNABLE;
                end
                OP_REMOVE: begin
                    if (w_hit && w_head.st != ST_UNUSED) begin
                        w_feed.st = ST_UNUSED;
                        w_feed.lock = 1'b0;
                        if (w_run_hit) n_runv = 1'b0;
                    end
                end
                OP_SETPRI: begin
                    if (w_hit && w_head.st != ST_UNUSED && r_np <= 4'd3)
                        w_feed.prio = r_np[1:0];
                end
                OP_LOCK: begin
                    if (w_run_hit) begin
                        w_feed.lock = 1'b1;
                        w_feed.lvl = 2'd0;
                        w_feed.arr = 32'd0;
                    end
                end
                OP_UNLOCK: begin
                    if (w_run_hit) begin
                        w_feed.lock = 1'b0;
                        w_feed.lvl = 2'd0;
                        w_feed.arr = 32'd0;
                        w_feed.prio = PRIO_MAX;
                        w_feed.used = 8'd0;
                    end
                end
                OP_SELECT: begin
                    // Slots arrive in descending order, so < keeps the higher slot on ties
                    if (!r_runv && w_head.st == ST_RUNNABLE && w_head.lvl != 2'd3) begin
                        if (!r_got || w_rank < r_brank ||
                            (w_rank == r_brank && w_head.arr < r_barr)) begin
                            n_got = 1'b1;
                            n_brank = w_rank;
                            n_barr = w_head.arr;
                            n_bslot = r_pos;
                        end
                    end
                end
                default: ;
            endcase
            // Status checks on the addressed slot while it passes the head
            if (r_cnt == '0 && !w_in_rng &&
                (r_op == OP_ADMIT || r_op == OP_WAKE || r_op == OP_REMOVE ||
                 r_op == OP_SETPRI))
                n_sts = STS_BAD;
            if (w_hit) begin
                if ((r_op == OP_ADMIT && w_head.st != ST_UNUSED) ||
                    (r_op == OP_WAKE && w_head.st != ST_SLEEPING) ||
                    (r_op == OP_REMOVE && w_head.st == ST_UNUSED) ||
                    (r_op == OP_SETPRI && (w_head.st == ST_UNUSED || r_np > 4'd3)))
                    n_sts = STS_BAD;
            end
            if (r_cnt == CW'(SLOTS - 1)) begin
                if ((r_op == OP_YIELD || r_op == OP_SLEEP) && r_runv) begin
                    n_runv = 1'b0;
                    if (r_boostp) n_tick = 32'd0;
                end
                if (r_op == OP_SELECT && !r_runv) begin
                    if (n_got) begin
                        n_runv = 1'b1;
                        n_run = 6'(n_bslot);
                    end else n_sts = STS_EMPTY;
                end
            end
        end else if (r_state == S_MARK) begin
            if (r_pos == r_bslot) begin
                w_feed.st = ST_RUNNING;
                n_runl = w_head.lvl;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) n_state = S_PASS;
            S_PASS: if (r_cnt == CW'(SLOTS - 1))
                        n_state = (r_op == OP_SELECT && !r_runv && n_got) ? S_MARK : S_OUT;
            S_MARK: if (r_cnt == CW'(SLOTS - 1)) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_boost <= BOOST_RST;
            r_q0 <= QUANT0_RST;
            r_q1 <= QUANT1_RST;
            r_q2 <= QUANT2_RST;
            r_tick <= 32'd0;
            r_run <= 6'd0;
            r_runv <= 1'b0;
            r_runl <= 2'd0;
            r_cnt <= '0;
            r_pos <= SW'(SLOTS - 1);
            r_ov <= 1'b0;
            r_got <= 1'b0;
            r_boostp <= 1'b0;
            r_sts <= STS_OK;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BOOST:  r_boost <= i_cfg_data;
                    CFG_QUANT0: r_q0 <= i_cfg_data[7:0];
                    CFG_QUANT1: r_q1 <= i_cfg_data[7:0];
                    CFG_QUANT2: r_q2 <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (w_ctl.rot) begin
                r_pos <= (r_pos == SW'(0)) ? SW'(SLOTS - 1) : r_pos - SW'(1);
                r_cnt <= (r_cnt == CW'(SLOTS - 1)) ? '0 : r_cnt + CW'(1);
            end
            r_got <= n_got;
            r_brank <= n_brank;
            r_barr <= n_barr;
            r_bslot <= n_bslot;
            r_runl <= n_runl;
            r_runv <= n_runv;
            r_run <= n_run;
            r_tick <= n_tick;
            r_sts <= n_sts;
            r_boostp <= n_boostp;
            if (w_acc) begin
                r_op <= w_iop;
                r_slot <= s_axis_tdata[9:4];
                r_np <= s_axis_tdata[13:10];
            end
            if (r_state == S_OUT) begin
                r_ov <= 1'b1;
                r_out <= {5'd0, r_sts, (r_runv ? r_runl : 2'd0), r_runv,
                          (r_runv ? r_run : 6'd0)};
            end else if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Level of the running slot is latched when it is marked running; 0 is sent when none runs.
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the multilevel feedback queue scheduler
// Drives scheduler requests with random gaps and stalls, predicts each
// result from a model of the slot table kept here, and compares field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlfq_pkg::*;

    localparam int NSLOT = 64;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] run_level;
        logic       run_valid;
        logic [5:0] run_slot;
    } t_result;

    class sched_scoreboard;
        t_slot_st   st[NSLOT];
        logic [1:0] lvl[NSLOT];
        logic [1:0] prio[NSLOT];
        logic [31:0] arr[NSLOT];
        logic [7:0] used[NSLOT];
        bit         locked[NSLOT];
        logic [31:0] ticks;
        logic [5:0] cur;
        bit         cur_ok;
        logic [15:0] boost_at;
        logic [7:0] quant[3];
        t_result    pending[$];
        int         errors;
        int         results_seen;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                st[i] = ST_UNUSED; lvl[i] = 0; prio[i] = 3; arr[i] = 0;
                used[i] = 0; locked[i] = 0;
            end
            ticks = 0; cur = 0; cur_ok = 0; errors = 0; results_seen = 0;
            boost_at = 16'd100; quant[0] = 8'd4; quant[1] = 8'd6; quant[2] = 8'd8;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_BOOST) boost_at = val;
            else if (idx == CFG_QUANT0) quant[0] = val[7:0];
            else if (idx == CFG_QUANT1) quant[1] = val[7:0];
            else quant[2] = val[7:0];
        endfunction

        // earliest arrival in a level (and priority when pr < 4), ties to higher slot
        function bit earliest(int l, int pr, ref int found);
            bit any;
            logic [31:0] best;
            any = 0; best = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (st[i] != ST_RUNNABLE || lvl[i] != l) continue;
                if (pr < 4 && prio[i] != pr) continue;
                if (!any || arr[i] <= best) begin
                    best = arr[i]; found = i; any = 1;
                end
            end
            return any;
        endfunction

        function void give_up(t_slot_st nxt);
            int s;
            bit reached;
            s = cur;
            reached = ticks >= {16'd0, boost_at};
            if (lvl[s] < 2 && used[s] >= quant[lvl[s]]) begin
                used[s] = 0; lvl[s] = lvl[s] + 2'd1; arr[s] = ticks;
            end else if (lvl[s] == 2 && used[s] >= quant[2]) begin
                used[s] = 0;
                if (prio[s] != 0) prio[s] = prio[s] - 2'd1;
            end
            if (locked[s]) begin
                lvl[s] = 0; arr[s] = 0; prio[s] = 3; used[s] = 0;
                if (reached) locked[s] = 0;
            end
            if (reached) begin
                for (int i = 0; i < NSLOT; i++) begin
                    prio[i] = 3; lvl[i] = 0; used[i] = 0;
                end
                ticks = 0;
            end
            st[s] = nxt;
            cur_ok = 0;
        endfunction

        function void note_request(t_op op, logic [5:0] s, logic [3:0] np);
            t_status sts;
            t_result r;
            int pick;
            bit got;
            sts = STS_OK; pick = 0; got = 0;
            case (op)
                OP_ADMIT: begin
                    if (st[s] != ST_UNUSED) sts = STS_BAD;
                    else begin
                        st[s] = ST_RUNNABLE; prio[s] = 3; used[s] = 0; lvl[s] = 0;
                        locked[s] = 0; arr[s] = ticks;
                    end
                end
                OP_TICK: begin
                    if (ticks != '1) ticks++;
                    if (cur_ok && used[cur] != 8'hFF) used[cur]++;
                end
                OP_YIELD, OP_SLEEP: begin
                    if (!cur_ok) sts = STS_BAD;
                    else give_up(op == OP_YIELD ? ST_RUNNABLE : ST_SLEEPING);
                end
                OP_WAKE: begin
                    if (st[s] != ST_SLEEPING) sts = STS_BAD;
                    else st[s] = ST_RUNNABLE;
                end
                OP_REMOVE: begin
                    if (st[s] == ST_UNUSED) sts = STS_BAD;
                    else begin
                        if (cur_ok && cur == s) cur_ok = 0;
                        st[s] = ST_UNUSED; locked[s] = 0;
                    end
                end
                OP_SETPRI: begin
                    if (np > 3 || st[s] == ST_UNUSED) sts = STS_BAD;
                    else prio[s] = np[1:0];
                end
                OP_LOCK: begin
                    if (!cur_ok) sts = STS_BAD;
                    else begin
                        ticks = 0; locked[cur] = 1; lvl[cur] = 0; arr[cur] = 0;
                    end
                end
                OP_UNLOCK: begin
                    if (!cur_ok) sts = STS_BAD;
                    else begin
                        locked[cur] = 0; lvl[cur] = 0; arr[cur] = 0;
                        prio[cur] = 3; used[cur] = 0;
                    end
                end
                OP_SELECT: begin
                    if (cur_ok) sts = STS_BAD;
                    else begin
                        for (int l = 0; l < 2 && !got; l++) got = earliest(l, 4, pick);
                        for (int p = 0; p < 4 && !got; p++) got = earliest(2, p, pick);
                        if (!got) sts = STS_EMPTY;
                        else begin
                            st[pick] = ST_RUNNING; cur = 6'(pick); cur_ok = 1;
                        end
                    end
                end
                default: sts = STS_BAD;
            endcase
            r.run_slot = cur_ok ? cur : 6'd0;
            r.run_valid = cur_ok;
            r.run_level = cur_ok ? lvl[cur] : 2'd0;
            r.status = sts;
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.run_slot !== exp.run_slot) begin
                $error("run_slot exp %0d got %0d", exp.run_slot, got.run_slot); errors++;
            end
            if (got.run_valid !== exp.run_valid) begin
                $error("run_valid exp %0d got %0d", exp.run_valid, got.run_valid); errors++;
            end
            if (got.run_level !== exp.run_level) begin
                $error("run_level exp %0d got %0d", exp.run_level, got.run_level); errors++;
            end
            if (got.status !== exp.status) begin
                $error("status exp %0d got %0d", exp.status, got.status); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    int send_idle_pct;
    int recv_idle_pct;
    sched_scoreboard sb;

    mlfq_task_scheduler_top u_dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // receiver: random stall, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_result'(m_axis_tdata[10:0]));
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // tvalid stays high after acceptance until the next idle cycle or drain
    task automatic send_request(t_op op, logic [5:0] s, logic [3:0] np);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, np, s, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, s, np);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * NSLOT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // mostly well-formed scheduling: admits, ticks, select and give-up cycles
    task automatic random_phase(int n);
        int k;
        t_op op;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 12) op = OP_ADMIT;
            else if (k < 40) op = OP_TICK;
            else if (k < 52) op = OP_YIELD;
            else if (k < 57) op = OP_SLEEP;
            else if (k < 63) op = OP_WAKE;
            else if (k < 67) op = OP_REMOVE;
            else if (k < 72) op = OP_SETPRI;
            else if (k < 75) op = OP_LOCK;
            else if (k < 78) op = OP_UNLOCK;
            else if (k < 98) op = OP_SELECT;
            else op = t_op'($urandom_range(15, 10));
            send_request(op, 6'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                           : $urandom_range(11)),
                         4'(($urandom_range(4) == 0) ? $urandom_range(15)
                                                     : $urandom_range(3)));
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 10;
        recv_idle_pct = 54;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty select, bad ops, extremes of slot and priority
        send_request(OP_SELECT, 0, 0);
        send_request(OP_YIELD, 0, 0);
        send_request(OP_LOCK, 0, 0);
        send_request(OP_UNLOCK, 0, 0);
        send_request(t_op'(4'hF), 6'h3F, 4'hF);
        send_request(OP_ADMIT, 6'h3F, 0);
        send_request(OP_ADMIT, 6'h3F, 0);
        send_request(OP_ADMIT, 0, 0);
        send_request(OP_SETPRI, 0, 4'hF);
        send_request(OP_SETPRI, 6'h3F, 0);
        send_request(OP_SETPRI, 1, 2);
        send_request(OP_SELECT, 0, 0);
        send_request(OP_SELECT, 0, 0);
        for (int i = 0; i < 5; i++) send_request(OP_TICK, 0, 0);
        send_request(OP_SLEEP, 0, 0);
        send_request(OP_WAKE, 0, 0);
        send_request(OP_WAKE, 0, 0);
        send_request(OP_SELECT, 0, 0);
        send_request(OP_LOCK, 0, 0);
        send_request(OP_UNLOCK, 0, 0);
        send_request(OP_REMOVE, 6'h3F, 0);
        send_request(OP_REMOVE, 0, 0);
        send_request(OP_REMOVE, 0, 0);
        drain();

        write_reg(CFG_BOOST, 16'd1);
        write_reg(CFG_QUANT0, 8'd1);
        write_reg(CFG_QUANT1, 8'd1);
        write_reg(CFG_QUANT2, 8'd1);
        i_cfg_we <= 0;
        random_phase(250);
        drain();

        send_idle_pct = 54;
        recv_idle_pct = 10;
        write_reg(CFG_BOOST, 16'hFFFF);
        write_reg(CFG_QUANT0, 8'hFF);
        write_reg(CFG_QUANT1, 8'd2);
        write_reg(CFG_QUANT2, 8'hFF);
        i_cfg_we <= 0;
        random_phase(250);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_BOOST, 16'd30);
        write_reg(CFG_QUANT0, 8'd3);
        write_reg(CFG_QUANT1, 8'd4);
        write_reg(CFG_QUANT2, 8'd2);
        i_cfg_we <= 0;
        random_phase(250);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[mlfq_task_scheduler_top] OK");
        end else begin
            $display("[mlfq_task_scheduler_top] ERROR");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("[mlfq_task_scheduler_top] ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/mlfq_pkg.sv
rtl/mlfq_cell.sv
rtl/mlfq_task_scheduler_top.sv
sim/tb.sv
